FILE: design/bulge_intensity_accumulate_top_assert.svh
// Assertion macros for the bulge intensity pipeline
`ifndef BULGE_INTENSITY_ACCUMULATE_TOP_ASSERT_SVH
`define BULGE_INTENSITY_ACCUMULATE_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define BIA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
// next-cycle implication
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define BIA_ASSERT_NOW(label, clk, rst, ante, cons)
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: design/bia_pkg.sv
// Types, constants and step functions of the bulge intensity pipeline
package bia_pkg;

   localparam int FRAC_BITS = 16;
   localparam int C001      = ((1 << FRAC_BITS) + 50) / 100;
   localparam int RAD_W     = FRAC_BITS + 3;
   localparam int K_W       = $clog2(RAD_W);
   localparam int MAG_W     = 36;
   localparam int X_W       = 40;
   localparam int N_W       = X_W - 30;

   localparam logic [31:0] CFG_ONE   = 32'(1 << FRAC_BITS);
   localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
   localparam logic [30:0] K_LOG2E   = 31'd1549082005;
   localparam logic [29:0] K_EXP855  = 30'd918049260;
   localparam logic [63:0] K_FLOOR05 = 64'd53687091;

   typedef enum logic [2:0] {
      CSR_STRENGTH       = 3'd0,
      CSR_RADIUS_GAIN    = 3'd1,
      CSR_INTENSITY_GAIN = 3'd2,
      CSR_SPEC_RED       = 3'd3,
      CSR_SPEC_GREEN     = 3'd4,
      CSR_SPEC_BLUE      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [63:0] rem;
      logic [63:0] root;
   } sqrt_stage_type;

   typedef struct packed {
      logic [30:0]      m;
      logic [29:0]      frac;
      logic [K_W-1:0]   k;
   } log_stage_type;

   typedef struct packed {
      logic signed [N_W-1:0] n;
      logic [29:0]           f;
      logic [30:0]           r;
   } exp_stage_type;

   typedef struct packed {
      logic [31:0]           rho;
      logic [31:0]           scale;
      logic [31:0]           acc_red;
      logic [31:0]           acc_green;
      logic [31:0]           acc_blue;
      logic                  big;
      logic signed [X_W-1:0] ea;
      logic [31:0]           level;
   } side_type;

   typedef struct packed {
      logic [31:0] sum_red;
      logic [31:0] sum_green;
      logic [31:0] sum_blue;
      logic [31:0] level;
   } word_type;

   function automatic logic [31:0] sat32(input logic [63:0] v);
      return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
   endfunction

   // one digit of the restoring square root, bit weight 4^i
   function automatic sqrt_stage_type sqrt_step(input sqrt_stage_type s, input int i);
      logic [63:0]    bitv;
      sqrt_stage_type o;
      bitv = 64'(1) << (2 * i);
      if (s.rem >= s.root + bitv) begin
         o.rem  = s.rem - (s.root + bitv);
         o.root = (s.root >> 1) + bitv;
      end else begin
         o.rem  = s.rem;
         o.root = s.root >> 1;
      end
      return o;
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      sqrt_stage_type s;
      s.rem  = v;
      s.root = '0;
      for (int i = 31; i >= 0; i--) s = sqrt_step(s, i);
      return s.root;
   endfunction

   // 2^(2^-(30-i)) in Q.30 by repeated square roots of 2.0
   function automatic logic [29:0][30:0] exp_tab();
      logic [63:0]       t;
      logic [29:0][30:0] tab;
      t = 64'(2) << 30;
      for (int i = 29; i >= 0; i--) begin
         t      = isqrt64(t << 30);
         tab[i] = t[30:0];
      end
      return tab;
   endfunction

   localparam logic [29:0][30:0] EXP_TAB = exp_tab();

   function automatic logic [K_W-1:0] lead_one(input logic [RAD_W-1:0] v);
      logic [K_W-1:0] k;
      k = '0;
      for (int i = 0; i < RAD_W; i++) if (v[i]) k = K_W'(i);
      return k;
   endfunction

   // square the mantissa, renormalize, emit one fraction bit
   function automatic log_stage_type log_step(input log_stage_type s, input int i);
      logic [61:0]   p;
      logic [31:0]   m2;
      log_stage_type o;
      o  = s;
      p  = 62'(s.m) * 62'(s.m);
      m2 = p[61:30];
      if (m2[31]) begin
         o.m       = m2[31:1];
         o.frac[i] = 1'b1;
      end else begin
         o.m = m2[30:0];
      end
      return o;
   endfunction

   function automatic exp_stage_type exp_start(input logic signed [X_W-1:0] x);
      exp_stage_type s;
      s.n = x[X_W-1:30];
      s.f = x[29:0];
      s.r = Q30_ONE;
      return s;
   endfunction

   function automatic exp_stage_type exp_next(input exp_stage_type s, input int i);
      logic [61:0]   p;
      exp_stage_type o;
      o = s;
      p = 62'(s.r) * 62'(EXP_TAB[i]);
      if (s.f[i]) o.r = p[60:30];
      return o;
   endfunction

   function automatic logic [63:0] exp_final(input exp_stage_type s);
      logic [N_W-1:0] neg_n;
      logic [5:0]     sh;
      logic [63:0]    res;
      neg_n = -s.n;
      if (s.n >= 0) begin
         sh  = (s.n > 32) ? 6'd32 : 6'(s.n);
         res = 64'(s.r) << sh;
      end else if (s.n <= -63) begin
         res = '0;
      end else begin
         res = 64'(s.r) >> neg_n[5:0];
      end
      return res;
   endfunction

endpackage

FILE: design/bulge_intensity_accumulate_top.sv
// Bulge intensity pipeline: radius, log2/exp2 shape, intensity and color accumulate
//
//   channel   dir   handshake             word
//   req       in    req_valid/req_stall   position, weight, pixel scale, RGB sums
//   rsp       out   rsp_valid/rsp_stall   updated RGB sums, bulge level
//   csr       in    csr_write             csr_index selects one of six gain registers
//
// One word per cycle sustained while no word is parked in the skid register.
// The depth is set by one multiply or root digit per stage: 32 square root stages,
// 30 mantissa squarings for log2 and two exp2 chains of 30 table multiplies each.
// Reset (synchronous) clears valid bits and loads every gain register with 1.0.
// A stalled output parks one more word in a skid register; then req_stall rises
// and the whole pipeline holds until the output is taken.
`include "bulge_intensity_accumulate_top_assert.svh"

module bulge_intensity_accumulate_top
   import bia_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic [31:0]         req_sample_weight,
   input  logic [31:0]         req_pixel_scale,
   input  logic [31:0]         req_accum_red,
   input  logic [31:0]         req_accum_green,
   input  logic [31:0]         req_accum_blue,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [31:0]         rsp_sum_red,
   output logic [31:0]         rsp_sum_green,
   output logic [31:0]         rsp_sum_blue,
   output logic [31:0]         rsp_bulge_level,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_data
);

   // stage map: index of the register stage that holds each result
   localparam int SQRT_N    = 32;
   localparam int LOG_N     = 30;
   localparam int EXP_N     = 30;
   localparam int ST_ROOT0  = 3;
   localparam int ST_PROD   = ST_ROOT0 + SQRT_N;
   localparam int ST_RAD    = ST_PROD + 1;
   localparam int ST_LOG0   = ST_RAD + 2;
   localparam int ST_MAGL   = ST_LOG0 + LOG_N;
   localparam int ST_ARG    = ST_MAGL + 1;
   localparam int ST_EAF    = ST_ARG + 1 + EXP_N;
   localparam int ST_EXPN   = ST_EAF + 1;
   localparam int ST_EBF    = ST_EXPN + 1 + EXP_N;
   localparam int ST_SHAPE  = ST_EBF + 1;
   localparam int ST_V      = ST_SHAPE + 1;
   localparam int ST_LEVEL  = ST_V + 1;
   localparam int ST_TSPEC  = ST_LEVEL + 1;
   localparam int ST_TSCALE = ST_TSPEC + 1;
   localparam int LAST      = ST_TSCALE;
   localparam int NST       = LAST + 1;

   // gain registers
   logic [31:0] cfg_strength_ff;
   logic [31:0] cfg_radius_ff;
   logic [31:0] cfg_gain_ff;
   logic [31:0] cfg_spec_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_strength_ff <= CFG_ONE;
         cfg_radius_ff   <= CFG_ONE;
         cfg_gain_ff     <= CFG_ONE;
         for (int c = 0; c < 3; c++) cfg_spec_ff[c] <= CFG_ONE;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_STRENGTH:       cfg_strength_ff <= csr_data;
            CSR_RADIUS_GAIN:    cfg_radius_ff   <= csr_data;
            CSR_INTENSITY_GAIN: cfg_gain_ff     <= csr_data;
            CSR_SPEC_RED:       cfg_spec_ff[0]  <= csr_data;
            CSR_SPEC_GREEN:     cfg_spec_ff[1]  <= csr_data;
            CSR_SPEC_BLUE:      cfg_spec_ff[2]  <= csr_data;
            default: ;
         endcase
      end
   end

   // pipeline control: every stage moves together unless the skid word is parked
   logic           adv;
   logic           skid_valid_ff;
   logic           rsp_valid_ff;
   logic [LAST:0]  vld_ff;

   assign adv       = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAST-1:0], req_valid};
      end
   end

   // side data: fields that ride along, plus values dropped in at their stage
   side_type              side_ff [NST];
   side_type              side_in [NST];
   side_type              side_in0;
   logic                  rad_big_in;
   logic signed [X_W-1:0] ea_in;
   logic [31:0]           level_in;

   always_comb begin
      side_in0.rho       = sat32((64'(cfg_strength_ff) * 64'(req_sample_weight)) >> FRAC_BITS);
      side_in0.scale     = req_pixel_scale;
      side_in0.acc_red   = req_accum_red;
      side_in0.acc_green = req_accum_green;
      side_in0.acc_blue  = req_accum_blue;
      side_in0.big       = 1'b0;
      side_in0.ea        = '0;
      side_in0.level     = '0;
   end

   // shift by one stage, then drop in the values computed along the way
   always_comb begin
      side_in[0] = side_in0;
      for (int j = 1; j < NST; j++) side_in[j] = side_ff[j-1];
      side_in[ST_RAD].big     = rad_big_in;
      side_in[ST_ARG].ea      = ea_in;
      side_in[ST_LEVEL].level = level_in;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < NST; j++) side_ff[j] <= side_in[j];
      end
   end

   // length: magnitudes, squares, sum, then one root digit per stage
   logic [31:0]    mag_ff [3];
   logic [63:0]    sq_ff [3];
   logic [63:0]    sumsq_ff;
   sqrt_stage_type sqrt_seed;
   sqrt_stage_type root_ff [SQRT_N];

   assign sqrt_seed.rem  = sumsq_ff;
   assign sqrt_seed.root = '0;

   always_ff @(posedge clock) begin
      if (adv) begin
         mag_ff[0] <= req_pos_x[31] ? 32'(-req_pos_x) : 32'(req_pos_x);
         mag_ff[1] <= req_pos_y[31] ? 32'(-req_pos_y) : 32'(req_pos_y);
         mag_ff[2] <= req_pos_z[31] ? 32'(-req_pos_z) : 32'(req_pos_z);
         for (int c = 0; c < 3; c++) sq_ff[c] <= 64'(mag_ff[c]) * 64'(mag_ff[c]);
         sumsq_ff   <= sq_ff[0] + sq_ff[1] + sq_ff[2];
         root_ff[0] <= sqrt_step(sqrt_seed, SQRT_N - 1);
         for (int j = 1; j < SQRT_N; j++) root_ff[j] <= sqrt_step(root_ff[j-1], SQRT_N - 1 - j);
      end
   end

   // radius, far-out flag, normalize to a Q.30 mantissa
   logic [31:0]       lenc;
   logic [63:0]       prod_ff;
   logic [63:0]       rad_full;
   logic [RAD_W-1:0]  rad_ff;
   logic [K_W-1:0]    nk;
   logic [K_W-1:0]    nk_ff;
   logic [30:0]       nm_ff;

   assign lenc       = root_ff[SQRT_N-1].root[31:0] + 32'(C001);
   assign rad_full   = (prod_ff >> FRAC_BITS) + 64'(C001);
   assign rad_big_in = rad_full >= (64'(8) << FRAC_BITS);
   assign nk         = lead_one(rad_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= 64'(lenc) * 64'(cfg_radius_ff);
         rad_ff  <= rad_full[RAD_W-1:0];
         nk_ff   <= nk;
         nm_ff   <= 31'(rad_ff) << (5'd30 - 5'(nk));
      end
   end

   // log2 fraction: one squaring per stage
   log_stage_type log_seed;
   log_stage_type log_ff [LOG_N];

   assign log_seed.m    = nm_ff;
   assign log_seed.frac = '0;
   assign log_seed.k    = nk_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         log_ff[0] <= log_step(log_seed, LOG_N - 1);
         for (int j = 1; j < LOG_N; j++) log_ff[j] <= log_step(log_ff[j-1], LOG_N - 1 - j);
      end
   end

   // |log2(rad)|, then the -0.855 power term and the quarter-power argument
   logic [5:0]            kk;
   logic [MAG_W-1:0]      magl_in;
   logic                  lneg_in;
   logic [MAG_W-1:0]      magl_ff;
   logic                  lneg_ff;
   logic [65:0]           pmp;
   logic [MAG_W-1:0]      qm;
   logic signed [X_W-1:0] q_ff;

   always_comb begin
      kk = 6'(log_ff[LOG_N-1].k);
      if (kk >= 6'(FRAC_BITS)) begin
         magl_in = (MAG_W'(kk - 6'(FRAC_BITS)) << 30) | MAG_W'(log_ff[LOG_N-1].frac);
         lneg_in = 1'b0;
      end else begin
         magl_in = (MAG_W'(6'(FRAC_BITS) - kk) << 30) - MAG_W'(log_ff[LOG_N-1].frac);
         lneg_in = 1'b1;
      end
   end

   assign pmp   = 66'(magl_ff) * 66'(K_EXP855);
   assign qm    = magl_ff >> 2;
   assign ea_in = lneg_ff ? $signed(X_W'(pmp[65:30])) : -$signed(X_W'(pmp[65:30]));

   always_ff @(posedge clock) begin
      if (adv) begin
         magl_ff <= magl_in;
         lneg_ff <= lneg_in;
         q_ff    <= lneg_ff ? -$signed(X_W'(qm)) : $signed(X_W'(qm));
      end
   end

   // first exp2 chain: 2^q, i.e. rad^0.25
   exp_stage_type         xa_ff [EXP_N];
   logic [63:0]           xa_full;
   logic [31:0]           xa_out_ff;
   logic [62:0]           lp;
   logic signed [X_W-1:0] e_ff;

   assign xa_full = exp_final(xa_ff[EXP_N-1]);
   assign lp      = 63'(xa_out_ff) * 63'(K_LOG2E);

   always_ff @(posedge clock) begin
      if (adv) begin
         xa_ff[0] <= exp_next(exp_start(q_ff), EXP_N - 1);
         for (int j = 1; j < EXP_N; j++) xa_ff[j] <= exp_next(xa_ff[j-1], EXP_N - 1 - j);
         xa_out_ff <= xa_full[31:0];
         e_ff      <= side_ff[ST_EXPN-1].ea - $signed(X_W'(lp[62:30]));
      end
   end

   // second exp2 chain: the shape value, then drop the floor and clamp
   exp_stage_type xb_ff [EXP_N];
   logic [63:0]   xb_full;
   logic [63:0]   shape_q30_ff;
   logic [31:0]   shape_in;
   logic [31:0]   shape_qf_ff;

   assign xb_full = exp_final(xb_ff[EXP_N-1]);

   always_comb begin
      if (side_ff[ST_SHAPE-1].big || shape_q30_ff <= K_FLOOR05) begin
         shape_in = '0;
      end else begin
         shape_in = sat32((shape_q30_ff - K_FLOOR05) >> (30 - FRAC_BITS));
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xb_ff[0] <= exp_next(exp_start(e_ff), EXP_N - 1);
         for (int j = 1; j < EXP_N; j++) xb_ff[j] <= exp_next(xb_ff[j-1], EXP_N - 1 - j);
         shape_q30_ff <= xb_full;
         shape_qf_ff  <= shape_in;
      end
   end

   // intensity and per-color contribution, one multiply per stage
   logic [31:0] v_ff;
   logic [31:0] tspec_ff [3];
   logic [31:0] tscale_ff [3];

   assign level_in = sat32((64'(v_ff) * 64'(cfg_gain_ff)) >> FRAC_BITS);

   always_ff @(posedge clock) begin
      if (adv) begin
         v_ff <= sat32((64'(side_ff[ST_V-1].rho) * 64'(shape_qf_ff)) >> FRAC_BITS);
         for (int c = 0; c < 3; c++) begin
            tspec_ff[c]  <= sat32((64'(side_ff[ST_TSPEC-1].level) * 64'(cfg_spec_ff[c]))
                                  >> FRAC_BITS);
            tscale_ff[c] <= sat32((64'(tspec_ff[c]) * 64'(side_ff[ST_TSCALE-1].scale))
                                  >> FRAC_BITS);
         end
      end
   end

   // final add into the output word
   word_type word_in;
   word_type out_ff;
   word_type skid_ff;
   logic     pipe_valid;

   assign pipe_valid        = vld_ff[LAST];
   assign word_in.sum_red   = sat32(64'(side_ff[LAST].acc_red) + 64'(tscale_ff[0]));
   assign word_in.sum_green = sat32(64'(side_ff[LAST].acc_green) + 64'(tscale_ff[1]));
   assign word_in.sum_blue  = sat32(64'(side_ff[LAST].acc_blue) + 64'(tscale_ff[2]));
   assign word_in.level     = side_ff[LAST].level;

   // output register plus skid: drain skid first, else load output, else park
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) skid_valid_ff <= 1'b0;
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) out_ff <= skid_ff;
      end else if (pipe_valid) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            out_ff <= word_in;
         end else begin
            skid_ff <= word_in;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sum_red     = out_ff.sum_red;
   assign rsp_sum_green   = out_ff.sum_green;
   assign rsp_sum_blue    = out_ff.sum_blue;
   assign rsp_bulge_level = out_ff.level;

   `BIA_ASSERT_NOW(a_skid_needs_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   `BIA_ASSERT_NEXT(a_hold_when_parked, clock, reset, skid_valid_ff, $stable(vld_ff))
   `BIA_ASSERT_NEXT(a_skid_drains, clock, reset, skid_valid_ff && !rsp_stall, rsp_valid_ff && out_ff == $past(skid_ff))
   `BIA_ASSERT_NEXT(a_far_is_dark, clock, reset, adv && vld_ff[ST_SHAPE-1] && side_ff[ST_SHAPE-1].big, shape_qf_ff == '0)

endmodule

FILE: verif/bulge_intensity_accumulate_top_tb.sv
// Self-checking testbench for the bulge intensity accumulate pipeline
`timescale 1ns / 1ps

module bulge_intensity_accumulate_top_tb;
   import bia_pkg::*;

   // Indexes past the last gain register: writes there must be dropped
   localparam logic [2:0] CSR_UNMAPPED_LO = 3'd6;
   localparam logic [2:0] CSR_UNMAPPED_HI = 3'd7;
   localparam int         NUM_GAINS       = 6;
   localparam int         TAIL_CYCLES     = 200;   // more than the pipeline depth
   localparam logic [63:0] MASK32  = 64'hFFFF_FFFF;
   localparam logic [63:0] MASK30  = 64'h3FFF_FFFF;
   localparam logic [63:0] ONE30   = 64'h4000_0000;
   localparam logic [63:0] LOG2E30 = 64'd1549082005;
   localparam logic [63:0] POW855  = 64'd918049260;
   localparam logic [63:0] FLOOR05 = 64'd53687091;
   localparam logic [63:0] CENTI   = ((64'd1 << FRAC_BITS) + 64'd50) / 64'd100;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [31:0]        req_sample_weight = '0;
   logic [31:0]        req_pixel_scale = '0;
   logic [31:0]        req_accum_red = '0;
   logic [31:0]        req_accum_green = '0;
   logic [31:0]        req_accum_blue = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [31:0]        rsp_sum_red;
   logic [31:0]        rsp_sum_green;
   logic [31:0]        rsp_sum_blue;
   logic [31:0]        rsp_bulge_level;
   logic               csr_write = 1'b0;
   logic [2:0]         csr_index = '0;
   logic [31:0]        csr_data = '0;

   // Predictor state: shadow gain registers and the exp2 root table
   logic [31:0] gain_shadow [NUM_GAINS];
   logic [63:0] root_tab [30];
   word_type    expected_words [$];
   int          error_count = 0;
   bit          calm = 1'b0;   // suppress all random idling on both sides

   bulge_intensity_accumulate_top u_top (.*);

   always #4 clock = ~clock;

   // Hard limit on the whole run
   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Output side stall: raised at random, none while calm
   always @(negedge clock) begin
      rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 19);
   end

   function automatic logic [63:0] int_sqrt(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] clip32(input logic [63:0] v);
      return (v > MASK32) ? MASK32 : v;
   endfunction

   function automatic logic [63:0] scale_q30(input logic [63:0] a, input logic [63:0] c);
      return (a >> 30) * c + (((a & MASK30) * c) >> 30);
   endfunction

   // 2^x, x signed Q.30, result unsigned Q.30; negative exponents floor
   function automatic logic [63:0] pow2_q30(input longint x);
      logic [63:0] ux;
      logic [63:0] f;
      logic [63:0] r;
      longint      n;
      r = ONE30;
      if (x >= 0) begin
         n = x >>> 30;
         f = 64'(x) & MASK30;
      end else begin
         ux = 64'd0 - 64'(x);
         if ((ux & MASK30) == 0) begin
            n = -longint'(ux >> 30);
            f = '0;
         end else begin
            n = -longint'(ux >> 30) - 1;
            f = ONE30 - (ux & MASK30);
         end
      end
      for (int i = 29; i >= 0; i--)
         if (f[i]) r = (r * root_tab[i]) >> 30;
      if (n >= 0) begin
         if (n > 32) n = 32;
         return r << n;
      end
      if (n <= -63) return '0;
      return r >> (-n);
   endfunction

   // rad^-0.855 * exp(-rad^0.25) - 0.05 in QF, clamped at zero
   function automatic logic [63:0] shape_of(input logic [63:0] rad);
      logic [63:0] m;
      logic [63:0] frac;
      logic [63:0] magl;
      logic [63:0] pm;
      logic [63:0] s;
      longint      l;
      longint      a;
      longint      q;
      longint      e;
      int          k;
      if (rad >= (64'd8 << FRAC_BITS) || rad == 0) return '0;
      k = 0;
      while ((rad >> (k + 1)) != 0) k++;
      m = rad << (30 - k);
      frac = '0;
      for (int i = 29; i >= 0; i--) begin
         m = (m * m) >> 30;
         if (m >= (ONE30 << 1)) begin
            m = m >> 1;
            frac[i] = 1'b1;
         end
      end
      l = longint'(k - FRAC_BITS) * longint'(ONE30) + longint'(frac);
      magl = (l < 0) ? 64'd0 - 64'(l) : 64'(l);
      pm = scale_q30(magl, POW855);
      a = (l < 0) ? longint'(pm) : -longint'(pm);
      q = (l < 0) ? -longint'(magl >> 2) : longint'(magl >> 2);
      e = a - longint'(scale_q30(pow2_q30(q), LOG2E30));
      s = pow2_q30(e);
      if (s <= FLOOR05) return '0;
      return (s - FLOOR05) >> (30 - FRAC_BITS);
   endfunction

   function automatic logic [63:0] abs32(input logic [31:0] raw);
      return raw[31] ? ((64'(~raw) + 64'd1) & MASK32) : 64'(raw);
   endfunction

   function automatic logic [31:0] tint(input logic [63:0] acc, input logic [63:0] level,
                                        input logic [63:0] spec, input logic [63:0] scale);
      logic [63:0] t;
      t = clip32((level * spec) >> FRAC_BITS);
      t = clip32((t * scale) >> FRAC_BITS);
      return 32'(clip32(acc + t));
   endfunction

   function automatic word_type shade_sample(input logic [31:0] px, input logic [31:0] py,
                                             input logic [31:0] pz, input logic [31:0] wt,
                                             input logic [31:0] sc, input logic [31:0] ar,
                                             input logic [31:0] ag, input logic [31:0] ab);
      logic [63:0] mx, my, mz, len, rad, rho, v, level;
      word_type    w;
      mx = abs32(px);
      my = abs32(py);
      mz = abs32(pz);
      len = int_sqrt(mx * mx + my * my + mz * mz);
      rad = (((len + CENTI) * 64'(gain_shadow[CSR_RADIUS_GAIN])) >> FRAC_BITS) + CENTI;
      rho = clip32((64'(gain_shadow[CSR_STRENGTH]) * 64'(wt)) >> FRAC_BITS);
      v = clip32((rho * shape_of(rad)) >> FRAC_BITS);
      level = clip32((v * 64'(gain_shadow[CSR_INTENSITY_GAIN])) >> FRAC_BITS);
      w.sum_red   = tint(64'(ar), level, 64'(gain_shadow[CSR_SPEC_RED]), 64'(sc));
      w.sum_green = tint(64'(ag), level, 64'(gain_shadow[CSR_SPEC_GREEN]), 64'(sc));
      w.sum_blue  = tint(64'(ab), level, 64'(gain_shadow[CSR_SPEC_BLUE]), 64'(sc));
      w.level     = 32'(level);
      return w;
   endfunction

   // Check every accepted output word against the oldest prediction
   task automatic check_field(input string label, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %h actual %h", $time, label, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: expected none actual %h %h %h %h", $time,
                     rsp_sum_red, rsp_sum_green, rsp_sum_blue, rsp_bulge_level);
            error_count++;
         end else begin
            want = expected_words.pop_front();
            check_field("sum_red", want.sum_red, rsp_sum_red);
            check_field("sum_green", want.sum_green, rsp_sum_green);
            check_field("sum_blue", want.sum_blue, rsp_sum_blue);
            check_field("bulge_level", want.level, rsp_bulge_level);
         end
      end
   end

   // Present one word, idling at random first; hold it until accepted
   task automatic send_sample(input logic [31:0] px, input logic [31:0] py,
                              input logic [31:0] pz, input logic [31:0] wt,
                              input logic [31:0] sc, input logic [31:0] ar,
                              input logic [31:0] ag, input logic [31:0] ab);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_pos_x = px;
      req_pos_y = py;
      req_pos_z = pz;
      req_sample_weight = wt;
      req_pixel_scale = sc;
      req_accum_red = ar;
      req_accum_green = ag;
      req_accum_blue = ab;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_words.push_back(shade_sample(px, py, pz, wt, sc, ar, ag, ab));
   endtask

   // Drop valid and wait until every prediction has been matched
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
   endtask

   // Write one register; only called with the pipeline empty
   task automatic write_gain(input logic [2:0] idx, input logic [31:0] value);
      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data = value;
      @(negedge clock);
      csr_write = 1'b0;
      if (idx < NUM_GAINS) gain_shadow[idx] = value;
   endtask

   // Positions mostly within 16.0 per axis, some anywhere
   function automatic logic [31:0] pick_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         2: return 32'($signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000);
         default: return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
      endcase
   endfunction

   function automatic logic [31:0] pick_q16();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(0, 32'h0004_0000);
         default: return $urandom_range(32'h0000_8000, 32'h0001_8000);
      endcase
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++)
         send_sample(pick_pos(), pick_pos(), pick_pos(), pick_q16(), pick_q16(),
                     pick_q16(), pick_q16(), pick_q16());
   endtask

   // Field extremes, origin, large radius and saturation
   task automatic test_directed();
      logic [31:0] one;
      one = CFG_ONE;
      send_sample('0, '0, '0, one, one, '0, '0, '0);
      send_sample('0, '0, '0, '1, '1, '0, '0, '0);
      send_sample('0, '0, '0, '1, '1, '1, '1, '1);
      send_sample(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, one, one, '0, '0, '0);
      send_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, '1, '1, '1, '1);
      send_sample(32'h0008_0000, '0, '0, one, one, 32'h1234_5678, '0, '1);
      send_sample(32'h0007_FFFF, '0, '0, one, one, '0, '0, '0);
      send_sample(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, one, one, '0, '0, '0);
      send_sample(32'h0000_0100, 32'hFFFF_FF00, '0, one, '0, '0, one, '0);
      send_sample('0, '0, 32'h0000_8000, '0, one, '1, '0, one);
      send_sample(32'h0004_0000, 32'h0002_0000, 32'h0001_0000, 32'h0100_0000, one,
                  32'hFFFF_0000, 32'hFFFF_0000, 32'hFFFF_0000);
      send_sample(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
   endtask

   // Default gains; first stretch with no idling on either side
   task automatic test_random_default();
      calm = 1'b1;
      send_random(120);
      calm = 1'b0;
      send_random(230);
   endtask

   // Sender holds off mid-stream until every result is back
   task automatic test_pressure();
      send_random(40);
      drain();
      send_random(40);
   endtask

   // Sweep gain settings, extremes among them, plus ignored indexes
   task automatic test_gain_sweep();
      logic [31:0] saved;
      for (int idx = 0; idx < NUM_GAINS; idx++) write_gain(3'(idx), '0);
      send_random(40);
      for (int idx = 0; idx < NUM_GAINS; idx++) write_gain(3'(idx), '1);
      send_random(40);
      for (int idx = 0; idx < NUM_GAINS; idx++) write_gain(3'(idx), CFG_ONE);
      write_gain(CSR_RADIUS_GAIN, 32'h0000_1000);
      write_gain(CSR_STRENGTH, 32'h0010_0000);
      send_random(60);
      for (int phase = 0; phase < 5; phase++) begin
         for (int idx = 0; idx < NUM_GAINS; idx++)
            write_gain(3'(idx), ($urandom_range(3) == 0) ? $urandom
                                                        : $urandom_range(0, 32'h0004_0000));
         send_random(60);
      end
      // Unmapped indexes must leave every gain untouched
      saved = gain_shadow[CSR_STRENGTH];
      write_gain(CSR_UNMAPPED_LO, 32'hDEAD_BEEF);
      write_gain(CSR_UNMAPPED_HI, 32'h0BAD_F00D);
      gain_shadow[CSR_STRENGTH] = saved;
      send_random(40);
   endtask

   initial begin
      logic [63:0] t;
      for (int i = 0; i < NUM_GAINS; i++) gain_shadow[i] = CFG_ONE;
      t = 64'd2 << 30;
      for (int i = 29; i >= 0; i--) begin
         t = int_sqrt(t << 30);
         root_tab[i] = t;
      end
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_random_default();
      test_pressure();
      test_gain_sweep();

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
